// File: design/pmt_pkg.sv
// Shared types, codes and defaults for the point multiset table.
package pmt_pkg;

  localparam int PMT_CAPACITY   = 64;
  localparam int PMT_COORD_BITS = 16;
  localparam int PMT_COUNT_BITS = 7;
  localparam int PMT_COUNT_MAX  = 127;
  localparam int PMT_STAT_BITS  = 2;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_COUNT_PAIR = 3'd2,
    OP_COUNT_X    = 3'd3,
    OP_COUNT_Y    = 3'd4
  } pmt_op_t;

  // Insert status codes
  localparam logic [PMT_STAT_BITS-1:0] STAT_NEW     = 2'd0;
  localparam logic [PMT_STAT_BITS-1:0] STAT_PRESENT = 2'd1;
  // Remove status codes
  localparam logic [PMT_STAT_BITS-1:0] STAT_REMOVED = 2'd0;
  localparam logic [PMT_STAT_BITS-1:0] STAT_ABSENT  = 2'd1;
  localparam logic [PMT_STAT_BITS-1:0] STAT_REMAIN  = 2'd2;
  localparam logic [PMT_STAT_BITS-1:0] STAT_LAST_X  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_COMMIT
  } pmt_state_t;

  typedef struct packed {
    logic clear;   // restart accumulators
    logic sample;  // read data valid this cycle
  } pmt_scan_ctrl_t;

  typedef struct packed {
    logic found_free;
    logic found_pair;
  } pmt_scan_flags_t;

endpackage

// File: design/pmt_ifs.sv
// Request and response channel interfaces of the point multiset table.
interface pmt_req_if import pmt_pkg::*; #(
  parameter int COORD_BITS = PMT_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   opcode;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;

  modport source (output valid, output opcode, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input opcode, input x_coord, input y_coord, output ready);
endinterface

interface pmt_rsp_if import pmt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PMT_COUNT_BITS-1:0] count;
  logic [PMT_STAT_BITS-1:0]  status;
  logic                      table_full;

  modport source (output valid, output count, output status, output table_full, input ready);
  modport sink   (input valid, input count, input status, input table_full, output ready);
endinterface

// File: design/pmt_mem.sv
// Simple dual-port table memory, one write and one registered read per cycle.
module pmt_mem import pmt_pkg::*; #(
  parameter int DATA_W = 1 + 2 * PMT_COORD_BITS,
  parameter int DEPTH  = PMT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/pmt_scan.sv
// Scan accumulator: match counts, first free entry and first matching entry.
module pmt_scan import pmt_pkg::*; #(
  parameter int CAPACITY   = PMT_CAPACITY,
  parameter int COORD_BITS = PMT_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pmt_scan_ctrl_t                ctrl,
  input  logic [$clog2(CAPACITY)-1:0]   idx,
  input  logic                          entry_valid,
  input  logic [COORD_BITS-1:0]         entry_x,
  input  logic [COORD_BITS-1:0]         entry_y,
  input  logic [COORD_BITS-1:0]         key_x,
  input  logic [COORD_BITS-1:0]         key_y,
  output pmt_scan_flags_t               flags,
  output logic [$clog2(CAPACITY)-1:0]   free_idx,
  output logic [$clog2(CAPACITY)-1:0]   pair_idx,
  output logic [$clog2(CAPACITY+1)-1:0] cnt_pair,
  output logic [$clog2(CAPACITY+1)-1:0] cnt_x,
  output logic [$clog2(CAPACITY+1)-1:0] cnt_y
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic x_hit;
  logic y_hit;

  assign x_hit = entry_valid && (entry_x == key_x);
  assign y_hit = entry_valid && (entry_y == key_y);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      flags <= '0;
    end else if (ctrl.sample) begin
      if (!entry_valid && !flags.found_free) begin
        flags.found_free <= 1'b1;
      end
      if (x_hit && y_hit && !flags.found_pair) begin
        flags.found_pair <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      cnt_pair <= '0;
      cnt_x    <= '0;
      cnt_y    <= '0;
    end else if (ctrl.sample) begin
      if (x_hit && y_hit) cnt_pair <= cnt_pair + CNT_W'(1);
      if (x_hit)          cnt_x    <= cnt_x + CNT_W'(1);
      if (y_hit)          cnt_y    <= cnt_y + CNT_W'(1);
      // lowest index wins
      if (!entry_valid && !flags.found_free) free_idx <= idx;
      if (x_hit && y_hit && !flags.found_pair) pair_idx <= idx;
    end
  end

endmodule

// File: design/point_multiset_table.sv
// Top level of the point multiset table.
//
// Point multiset table: a bounded multiset of signed (x,y) points, one table
// entry per occurrence, held in a single memory of CAPACITY words of
// {valid, x, y}. Each request item carries an opcode (insert, remove, count
// pair, count x, count y) and one point; exactly one response item follows.
// Every item scans the whole memory through its one read port, one entry per
// cycle, then spends a flush state on the last read's data and a commit state
// that writes back at most one entry and loads the response register, and the
// next item is accepted on the cycle after commit. The response register lets
// the table take the next item while the previous response is still waiting;
// commit stalls only if that register is still full. After reset the table
// runs a clearing pass that zeroes every valid mark; no request is accepted
// meanwhile. Insert picks the lowest free entry; remove clears the lowest
// entry holding the pair. Counts saturate at 127. Opcodes 5 to 7 change
// nothing and answer zeros.
module point_multiset_table import pmt_pkg::*; #(
  parameter int CAPACITY   = PMT_CAPACITY,
  parameter int COORD_BITS = PMT_COORD_BITS
) (
  input  logic     clk,
  input  logic     rst,
  pmt_req_if.sink  req,
  pmt_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DATA_W = 1 + 2 * COORD_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  function automatic logic [PMT_COUNT_BITS-1:0] clamp_count(input logic [CNT_W-1:0] n);
    logic [31:0] wide;
    wide = 32'(n);
    return (wide > 32'(PMT_COUNT_MAX)) ? PMT_COUNT_BITS'(PMT_COUNT_MAX)
                                       : wide[PMT_COUNT_BITS-1:0];
  endfunction

  // Control state
  pmt_state_t state, state_next;
  logic [IDX_W-1:0] addr, addr_next;   // clear / scan address
  logic             rd_sample;         // read issued last cycle
  logic [IDX_W-1:0] rd_idx;            // address of the data now on rdata
  logic             rsp_valid;

  // Latched request
  logic [2:0]            op;
  logic [COORD_BITS-1:0] key_x;
  logic [COORD_BITS-1:0] key_y;

  // Response payload
  logic [PMT_COUNT_BITS-1:0] rsp_count;
  logic [PMT_STAT_BITS-1:0]  rsp_status;
  logic                      rsp_full;

  // Memory port
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [DATA_W-1:0] mem_rdata;

  // Scan results
  pmt_scan_ctrl_t   scan_ctrl;
  pmt_scan_flags_t  flags;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] pair_idx;
  logic [CNT_W-1:0] cnt_pair;
  logic [CNT_W-1:0] cnt_x;
  logic [CNT_W-1:0] cnt_y;

  // Commit-cycle decisions
  logic                      last;
  logic                      commit;
  logic                      wr_wanted;
  logic [PMT_COUNT_BITS-1:0] res_count;
  logic [PMT_STAT_BITS-1:0]  res_status;
  logic                      res_full;

  pmt_mem #(
    .DATA_W (DATA_W),
    .DEPTH  (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  pmt_scan #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (scan_ctrl),
    .idx         (rd_idx),
    .entry_valid (mem_rdata[DATA_W-1]),
    .entry_x     (mem_rdata[2*COORD_BITS-1:COORD_BITS]),
    .entry_y     (mem_rdata[COORD_BITS-1:0]),
    .key_x       (key_x),
    .key_y       (key_y),
    .flags       (flags),
    .free_idx    (free_idx),
    .pair_idx    (pair_idx),
    .cnt_pair    (cnt_pair),
    .cnt_x       (cnt_x),
    .cnt_y       (cnt_y)
  );

  assign last = (addr == LAST_IDX);

  assign rsp.valid      = rsp_valid;
  assign rsp.count      = rsp_count;
  assign rsp.status     = rsp_status;
  assign rsp.table_full = rsp_full;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (last) state_next = ST_IDLE;
      ST_IDLE:   if (req.valid) state_next = ST_SCAN;
      ST_SCAN:   if (last) state_next = ST_FLUSH;
      ST_FLUSH:  state_next = ST_COMMIT;
      ST_COMMIT: if (commit) state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    req.ready        = 1'b0;
    mem_re           = 1'b0;
    wr_wanted        = 1'b0;
    mem_waddr        = addr;
    mem_wdata        = '0;
    commit           = 1'b0;
    res_count        = '0;
    res_status       = STAT_NEW;
    res_full         = 1'b0;
    addr_next        = '0;
    scan_ctrl.clear  = (state == ST_IDLE);
    scan_ctrl.sample = rd_sample;
    unique case (state)
      ST_CLEAR: begin
        wr_wanted = 1'b1;
        addr_next = last ? '0 : addr + IDX_W'(1);
      end
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_SCAN: begin
        mem_re    = 1'b1;
        addr_next = last ? '0 : addr + IDX_W'(1);
      end
      ST_FLUSH: begin
      end
      ST_COMMIT: begin
        commit = !rsp_valid || rsp.ready;
        unique case (op)
          OP_INSERT: begin
            if (flags.found_free) begin
              wr_wanted  = 1'b1;
              mem_waddr  = free_idx;
              mem_wdata  = {1'b1, key_x, key_y};
              res_status = (cnt_pair == '0) ? STAT_NEW : STAT_PRESENT;
            end else begin
              res_full = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (flags.found_pair) begin
              wr_wanted = 1'b1;
              mem_waddr = pair_idx;
              mem_wdata = {1'b0, key_x, key_y};
              // counts include the occurrence being removed
              if (cnt_x == CNT_W'(1)) begin
                res_status = STAT_LAST_X;
              end else if (cnt_pair == CNT_W'(1)) begin
                res_status = STAT_REMOVED;
              end else begin
                res_status = STAT_REMAIN;
              end
            end else begin
              res_status = STAT_ABSENT;
            end
          end
          OP_COUNT_PAIR: res_count = clamp_count(cnt_pair);
          OP_COUNT_X:    res_count = clamp_count(cnt_x);
          OP_COUNT_Y:    res_count = clamp_count(cnt_y);
          default: begin
          end
        endcase
      end
    endcase
    // clearing pass writes unconditionally; commit writes only when it fires
    mem_we = wr_wanted && ((state == ST_CLEAR) || commit);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      addr      <= '0;
      rd_sample <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      addr      <= addr_next;
      rd_sample <= mem_re;
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (req.valid && req.ready) begin
      op    <= req.opcode;
      key_x <= req.x_coord;
      key_y <= req.y_coord;
    end
    if (commit) begin
      rsp_count  <= res_count;
      rsp_status <= res_status;
      rsp_full   <= res_full;
    end
  end

`ifndef SYNTH
  // No write may land in the memory while a scan is reading it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_FLUSH) |-> !mem_we)
    else $error("table written during scan");

  // A response only appears out of the commit cycle
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_COMMIT)
    else $error("response raised outside commit");

  // A refused insert carries no status or count
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.table_full) |-> (rsp.status == STAT_NEW && rsp.count == '0))
    else $error("table_full with nonzero status or count");

  // An accepted item starts its scan at entry zero
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_SCAN && addr == '0))
    else $error("scan did not start at entry zero");
`endif

endmodule

// File: test/point_multiset_table_test.sv
// Self-checking testbench for the point multiset table: shadow table, random traffic, backpressure.
`timescale 1ns / 1ps

module point_multiset_table_test;
  import pmt_pkg::*;

  typedef logic signed [PMT_COORD_BITS-1:0] coord_t;

  // One response item as the block presents it.
  typedef struct packed {
    logic [PMT_COUNT_BITS-1:0] count;
    logic [PMT_STAT_BITS-1:0]  status;
    logic                      table_full;
  } rsp_item_t;

  // Opcodes with no meaning; the block must answer zeros and leave the table alone.
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam coord_t CMAX = 16'sh7fff;
  localparam coord_t CMIN = 16'sh8000;

  // Watchdog: cycles without any item moving on either channel. Worst honest case is a
  // receiver hold-off plus a full scan plus the longest sender gap and receiver stall.
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int POOL_SIZE       = 8;

  logic clk;
  logic rst;

  pmt_req_if req_ch ();
  pmt_rsp_if rsp_ch ();

  point_multiset_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table; updated in acceptance order, which is also response order.
  logic   shadow_valid [PMT_CAPACITY];
  coord_t shadow_x     [PMT_CAPACITY];
  coord_t shadow_y     [PMT_CAPACITY];

  rsp_item_t expected_rsp_q[$];

  int err_count;
  int rsp_seen;
  int idle_cycles;

  // Traffic shaping knobs, flipped by the test tasks.
  bit gaps_on;
  bit stalls_on;
  int hold_off_left;

  // Coordinate pools, so random traffic actually hits stored points.
  coord_t x_pool [POOL_SIZE];
  coord_t y_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table model
  // ---------------------------------------------------------------------------

  function automatic int match_count(input bit use_x, input coord_t x,
                                     input bit use_y, input coord_t y);
    int n;
    n = 0;
    for (int i = 0; i < PMT_CAPACITY; i++) begin
      if (shadow_valid[i] && (!use_x || shadow_x[i] == x) && (!use_y || shadow_y[i] == y))
        n++;
    end
    return n;
  endfunction

  // Count field saturates; only matters for tables deeper than the field allows.
  function automatic logic [PMT_COUNT_BITS-1:0] sat_count(input int n);
    return (n > PMT_COUNT_MAX) ? PMT_COUNT_BITS'(PMT_COUNT_MAX) : PMT_COUNT_BITS'(n);
  endfunction

  function automatic int table_occupancy();
    int n;
    n = 0;
    for (int i = 0; i < PMT_CAPACITY; i++)
      if (shadow_valid[i]) n++;
    return n;
  endfunction

  // Applies one operation to the shadow table and returns the response it must produce.
  function automatic rsp_item_t table_apply(input logic [2:0] op, input coord_t x,
                                            input coord_t y);
    rsp_item_t r;
    int slot;
    r = '0;
    slot = -1;
    case (op)
      OP_INSERT: begin
        // lowest free entry takes the point
        for (int i = 0; i < PMT_CAPACITY; i++)
          if (!shadow_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.table_full = 1'b1;
        end else begin
          r.status = (match_count(1'b1, x, 1'b1, y) == 0) ? STAT_NEW : STAT_PRESENT;
          shadow_valid[slot] = 1'b1;
          shadow_x[slot]     = x;
          shadow_y[slot]     = y;
        end
      end
      OP_REMOVE: begin
        // lowest entry holding the pair goes away
        for (int i = 0; i < PMT_CAPACITY; i++)
          if (shadow_valid[i] && shadow_x[i] == x && shadow_y[i] == y && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = STAT_ABSENT;
        end else begin
          shadow_valid[slot] = 1'b0;
          if (match_count(1'b1, x, 1'b0, y) == 0)
            r.status = STAT_LAST_X;
          else if (match_count(1'b1, x, 1'b1, y) == 0)
            r.status = STAT_REMOVED;
          else
            r.status = STAT_REMAIN;
        end
      end
      OP_COUNT_PAIR: r.count = sat_count(match_count(1'b1, x, 1'b1, y));
      OP_COUNT_X:    r.count = sat_count(match_count(1'b1, x, 1'b0, y));
      OP_COUNT_Y:    r.count = sat_count(match_count(1'b0, x, 1'b1, y));
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Every response item is compared field by field against the oldest prediction.
  always @(posedge clk) begin
    rsp_item_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with no request pending", rsp_seen));
      end else begin
        exp_r = expected_rsp_q.pop_front();
        if (rsp_ch.count !== exp_r.count)
          report_mismatch($sformatf("response %0d count exp %0d got %0d",
                                    rsp_seen, exp_r.count, rsp_ch.count));
        if (rsp_ch.status !== exp_r.status)
          report_mismatch($sformatf("response %0d status exp %0d got %0d",
                                    rsp_seen, exp_r.status, rsp_ch.status));
        if (rsp_ch.table_full !== exp_r.table_full)
          report_mismatch($sformatf("response %0d table_full exp %0b got %0b",
                                    rsp_seen, exp_r.table_full, rsp_ch.table_full));
      end
      rsp_seen++;
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Traffic helpers
  // ---------------------------------------------------------------------------

  // Gap/stall lengths: mostly short, a few long enough to cover a whole scan.
  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 93) return $urandom_range(5, 40);
    return $urandom_range(41, 150);
  endfunction

  // Response side: random stalls, plus a counted hold-off when a test asks for one.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 99) < 20) begin
        rsp_ch.ready = 1'b0;
        stall_left = pick_gap_len() - 1;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is accepted,
  // with valid still high so back-to-back items follow without a gap.
  task automatic send_item(input logic [2:0] op, input coord_t x, input coord_t y);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 50) gap = pick_gap_len();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.opcode  = op;
    req_ch.x_coord = x;
    req_ch.y_coord = y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rsp_q.push_back(table_apply(op, x, y));
    @(negedge clk);
  endtask

  // Sender pauses until every outstanding response has come back.
  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
  endtask

  // Removes every stored point, lowest entry first.
  task automatic empty_table();
    for (int i = 0; i < PMT_CAPACITY; i++)
      if (shadow_valid[i]) send_item(OP_REMOVE, shadow_x[i], shadow_y[i]);
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < POOL_SIZE; i++) begin
      x_pool[i] = coord_t'($urandom_range(0, 65535));
      y_pool[i] = coord_t'($urandom_range(0, 65535));
    end
    // keep the coordinate extremes in play
    x_pool[0] = CMIN;
    x_pool[1] = CMAX;
    y_pool[0] = CMAX;
    y_pool[1] = CMIN;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked items: empty-table queries, duplicates, every remove outcome,
  // count-x ignoring y, and the meaningless opcodes.
  task automatic test_directed();
    send_item(OP_COUNT_PAIR, 16'sd0, 16'sd0);
    send_item(OP_COUNT_X, CMIN, 16'sd0);
    send_item(OP_COUNT_Y, 16'sd0, CMAX);
    send_item(OP_REMOVE, 16'sd5, 16'sd5);          // remove from an empty table
    send_item(OP_INSERT, CMAX, CMIN);              // new pair
    send_item(OP_INSERT, CMAX, CMIN);              // duplicate
    send_item(OP_INSERT, CMIN, CMAX);
    send_item(OP_INSERT, CMAX, 16'sd0);
    send_item(OP_INSERT, 16'sd0, 16'sd0);
    send_item(OP_COUNT_PAIR, CMAX, CMIN);
    send_item(OP_COUNT_X, CMAX, 16'sh5a5a);        // y must not matter
    send_item(OP_COUNT_Y, 16'sh1234, CMIN);
    send_item(OP_REMOVE, CMAX, 16'sh7ffe);         // x present, pair absent
    send_item(OP_REMOVE, CMIN + 16'sd1, CMAX);     // x absent
    send_item(OP_REMOVE, CMAX, CMIN);              // a copy remains
    send_item(OP_REMOVE, CMAX, CMIN);              // pair gone, x still present
    send_item(OP_REMOVE, CMAX, 16'sd0);            // last point with this x
    send_item(OP_REMOVE, CMAX, 16'sd0);            // now absent
    send_item(OP_RSVD_5, CMIN, CMIN);
    send_item(OP_RSVD_6, CMAX, CMAX);
    send_item(OP_RSVD_7, -16'sd1, -16'sd1);
    send_item(OP_COUNT_PAIR, CMIN, CMAX);
    send_item(OP_INSERT, -16'sd1, -16'sd1);
    send_item(OP_COUNT_Y, 16'sd0, -16'sd1);
    wait_drained();
  endtask

  // Fill the table to the last entry: refused insert, counts of 64, then refill
  // with mixed points and reuse of a freed hole.
  task automatic test_table_full();
    empty_table();
    repeat (PMT_CAPACITY) send_item(OP_INSERT, -16'sd1, CMIN);
    send_item(OP_INSERT, -16'sd1, CMIN);           // refused, table full
    send_item(OP_INSERT, 16'sd3, 16'sd4);          // refused as well
    send_item(OP_COUNT_PAIR, -16'sd1, CMIN);
    send_item(OP_COUNT_X, -16'sd1, 16'sd0);
    send_item(OP_COUNT_Y, CMAX, CMIN);
    repeat (PMT_CAPACITY) send_item(OP_REMOVE, -16'sd1, CMIN);
    for (int i = 0; i < PMT_CAPACITY; i++)
      send_item(OP_INSERT, coord_t'(i / 4 - 8), coord_t'(i * 1031));
    send_item(OP_INSERT, CMIN, CMIN);              // refused
    send_item(OP_COUNT_X, 16'sd0, 16'sd0);
    send_item(OP_REMOVE, shadow_x[10], shadow_y[10]);
    send_item(OP_INSERT, CMAX, CMAX);              // lands in the freed hole
    send_item(OP_INSERT, CMAX, CMAX);              // refused again
    send_item(OP_COUNT_PAIR, CMAX, CMAX);
    send_item(OP_REMOVE, CMAX, CMAX);
    empty_table();
    wait_drained();
  endtask

  // Receiver holds off long enough for the response register to fill and the
  // block to stall its input while the sender keeps offering items.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    send_item(OP_INSERT, 16'sd7, 16'sd7);
    send_item(OP_INSERT, 16'sd7, -16'sd7);
    send_item(OP_COUNT_X, 16'sd7, 16'sd0);
    send_item(OP_REMOVE, 16'sd7, 16'sd7);
    send_item(OP_COUNT_Y, 16'sd0, -16'sd7);
    send_item(OP_REMOVE, 16'sd7, -16'sd7);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // Random operations over a small coordinate pool so inserts, removes and counts
  // keep meeting each other; a share of fully random coordinates and bad opcodes.
  task automatic test_random_mix(input int n_items, input int insert_pct, input int remove_pct);
    logic [2:0] op;
    coord_t x;
    coord_t y;
    int r;
    int idx;
    refresh_pools();
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) begin
        x = x_pool[$urandom_range(0, POOL_SIZE - 1)];
        y = y_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        x = coord_t'($urandom_range(0, 65535));
        y = coord_t'($urandom_range(0, 65535));
      end
      if (r < insert_pct) begin
        op = OP_INSERT;
      end else if (r < insert_pct + remove_pct) begin
        op = OP_REMOVE;
      end else if (r < 96) begin
        case ($urandom_range(0, 2))
          0:       op = OP_COUNT_PAIR;
          1:       op = OP_COUNT_X;
          default: op = OP_COUNT_Y;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_RSVD_5;
          1:       op = OP_RSVD_6;
          default: op = OP_RSVD_7;
        endcase
      end
      // removes and counts mostly aim at a point that is really stored
      if (op != OP_INSERT && table_occupancy() > 0 && $urandom_range(0, 99) < 65) begin
        idx = $urandom_range(0, PMT_CAPACITY - 1);
        while (!shadow_valid[idx]) idx = (idx + 1) % PMT_CAPACITY;
        x = shadow_x[idx];
        y = shadow_y[idx];
      end
      send_item(op, x, y);
    end
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_mix(150, 40, 35);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.opcode  = OP_INSERT;
    req_ch.x_coord = '0;
    req_ch.y_coord = '0;
    err_count      = 0;
    rsp_seen       = 0;
    idle_cycles    = 0;
    hold_off_left  = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    for (int i = 0; i < PMT_CAPACITY; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_x[i]     = '0;
      shadow_y[i]     = '0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;   // the block's clearing pass holds ready low for a while

    test_directed();
    test_table_full();
    test_backpressure();
    test_random_mix(320, 40, 30);
    test_random_mix(260, 70, 15);   // drives the table to full
    test_random_mix(260, 15, 70);   // drains it again
    test_streaming();
    test_random_mix(300, 45, 35);
    test_backpressure();

    // nothing outstanding; give the block a scan's worth of time to misbehave
    wait_drained();
    repeat (PMT_CAPACITY + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/pmt_pkg.sv
design/pmt_ifs.sv
design/pmt_mem.sv
design/pmt_scan.sv
design/point_multiset_table.sv
test/point_multiset_table_test.sv
